// ===== design/bpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfs_pkg
// Shared constants and types for the binary pattern flippability score block.
// ----------------------------------------------------------------------------
package bpfs_pkg;

    localparam int WINDOW_SIDE = 3;
    localparam int NPIX        = WINDOW_SIDE * WINDOW_SIDE;
    localparam int CENTRE      = (WINDOW_SIDE / 2) * WINDOW_SIDE + (WINDOW_SIDE / 2);

    // Every pixel except the center, i.e. the outer ring of the window.
    localparam logic [NPIX-1:0] RING_MASK = ~(NPIX'(1) << CENTRE);

    localparam logic [3:0] SCORE_BASE = 4'd4;
    localparam logic [2:0] DIAG_LOW   = 3'd3;

    // Transition counts in the four directions.
    typedef struct packed {
        logic [2:0] h;
        logic [2:0] v;
        logic [2:0] d;
        logic [2:0] a;
    } trans_t;

    // Terms of the Euler relation for one color: clusters = vtx + faces - edges.
    typedef struct packed {
        logic [3:0] vtx;
        logic [3:0] edges;
        logic [2:0] faces;
    } clus_part_t;

    typedef struct packed {
        trans_t     trans;
        clus_part_t col0;
        clus_part_t col1;
    } count_t;

    // Rule conditions, evaluated one stage ahead of the score.
    typedef struct packed {
        logic zero_score;
        logic diag_zero;
        logic diag_low;
        logic same;
        logic rougher;
        logic conn_change;
    } flags_t;

endpackage

// ===== design/binary_pattern_flippability_score.sv =====
// ----------------------------------------------------------------------------
// binary_pattern_flippability_score
// Flippability score in eighths of a 3x3 binary pattern, four-stage pipeline.
// ----------------------------------------------------------------------------
// done follows an accepted request through the input, counts, rule-flag and score registers.
// Throughput: one request per cycle; the four register stages (input, counts,
// rule flags, score) each hold one pattern, so busy is always low.
// Reset clears the valid bit of every stage; payload registers are not reset.
// The result is shown for one cycle with done; the receiver cannot stall it.
module binary_pattern_flippability_score
    import bpfs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [NPIX-1:0] pattern_bits,
    output logic            done,
    output logic [2:0]      score_eighths
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic            s2_valid_reg;
    logic            s3_valid_reg;
    logic            done_reg;
    logic [NPIX-1:0] pattern_reg;
    count_t          cnt_p;
    count_t          cnt_f;

    assign busy          = 1'b0;
    assign s1_valid_next = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            pattern_reg <= pattern_bits;
        end
    end

    bpfs_count u_count_p
    (
        .clk     (clk),
        .pattern (pattern_reg),
        .counts  (cnt_p)
    );

    // Same pattern with the center pixel inverted.
    bpfs_count u_count_f
    (
        .clk     (clk),
        .pattern (pattern_reg ^ (NPIX'(1) << CENTRE)),
        .counts  (cnt_f)
    );

    bpfs_rules u_rules
    (
        .clk   (clk),
        .cnt_p (cnt_p),
        .cnt_f (cnt_f),
        .score (score_eighths)
    );

    assign done = done_reg;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s3_valid_reg))
        else $error("done without a request in the rule stage");

    a_request_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> ##2 done)
        else $error("accepted request did not produce a result");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (score_eighths <= 3'd6))
        else $error("score out of range");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline reported busy");

endmodule

// ===== design/bpfs_count.sv =====
// ----------------------------------------------------------------------------
// bpfs_count
// Transition counts and cluster terms of one 3x3 pattern, registered.
// ----------------------------------------------------------------------------
module bpfs_count
    import bpfs_pkg::*;
(
    input  logic            clk,
    input  logic [NPIX-1:0] pattern,
    output count_t          counts
);

    count_t counts_reg;
    count_t counts_next;

    // Clusters of one color: a planar grid graph has V - E + F components,
    // where the bounded faces are full 2x2 squares and the ring around a
    // center of the other color.
    function automatic clus_part_t part(input logic [NPIX-1:0] m);
        clus_part_t res;
        int         r;
        int         c;
        res.vtx   = 4'd0;
        res.edges = 4'd0;
        res.faces = 3'd0;
        for (r = 0; r < NPIX; r++)
        begin
            res.vtx = res.vtx + 4'(m[r]);
        end
        for (r = 0; r < WINDOW_SIDE; r++)
        begin
            for (c = 0; c + 1 < WINDOW_SIDE; c++)
            begin
                res.edges = res.edges
                    + 4'(m[r*WINDOW_SIDE+c] & m[r*WINDOW_SIDE+c+1])
                    + 4'(m[c*WINDOW_SIDE+r] & m[(c+1)*WINDOW_SIDE+r]);
            end
        end
        for (r = 0; r + 1 < WINDOW_SIDE; r++)
        begin
            for (c = 0; c + 1 < WINDOW_SIDE; c++)
            begin
                res.faces = res.faces + 3'(m[r*WINDOW_SIDE+c] & m[r*WINDOW_SIDE+c+1]
                    & m[(r+1)*WINDOW_SIDE+c] & m[(r+1)*WINDOW_SIDE+c+1]);
            end
        end
        res.faces = res.faces + 3'(((m & RING_MASK) == RING_MASK) && !m[CENTRE]);
        return res;
    endfunction

    always_comb
    begin
        int r;
        int c;
        counts_next.trans = '0;
        for (r = 0; r < WINDOW_SIDE; r++)
        begin
            for (c = 0; c + 1 < WINDOW_SIDE; c++)
            begin
                counts_next.trans.h = counts_next.trans.h
                    + 3'(pattern[r*WINDOW_SIDE+c] ^ pattern[r*WINDOW_SIDE+c+1]);
                counts_next.trans.v = counts_next.trans.v
                    + 3'(pattern[c*WINDOW_SIDE+r] ^ pattern[(c+1)*WINDOW_SIDE+r]);
            end
        end
        for (r = 0; r + 1 < WINDOW_SIDE; r++)
        begin
            for (c = 0; c + 1 < WINDOW_SIDE; c++)
            begin
                counts_next.trans.d = counts_next.trans.d
                    + 3'(pattern[r*WINDOW_SIDE+c] ^ pattern[(r+1)*WINDOW_SIDE+c+1]);
                counts_next.trans.a = counts_next.trans.a
                    + 3'(pattern[(r+1)*WINDOW_SIDE+c] ^ pattern[r*WINDOW_SIDE+c+1]);
            end
        end
        counts_next.col0 = part(~pattern);
        counts_next.col1 = part(pattern);
    end

    always_ff @(posedge clk)
    begin
        counts_reg <= counts_next;
    end

    assign counts = counts_reg;

endmodule

// ===== design/bpfs_rules.sv =====
// ----------------------------------------------------------------------------
// bpfs_rules
// Rule conditions from both sets of counts, then the score in eighths.
// ----------------------------------------------------------------------------
module bpfs_rules
    import bpfs_pkg::*;
(
    input  logic       clk,
    input  count_t     cnt_p,
    input  count_t     cnt_f,
    output logic [2:0] score
);

    flags_t     flags_reg;
    flags_t     flags_next;
    logic [2:0] score_reg;
    logic [2:0] score_next;

    function automatic logic [2:0] clusters(input clus_part_t x);
        return 3'(4'(x.vtx + 4'(x.faces)) - x.edges);
    endfunction

    function automatic logic [4:0] total(input trans_t t);
        return 5'(t.h) + 5'(t.v) + 5'(t.d) + 5'(t.a);
    endfunction

    always_comb
    begin
        trans_t t;
        trans_t tf;
        t  = cnt_p.trans;
        tf = cnt_f.trans;
        flags_next.zero_score = (total(t) == 5'd0) || (total(tf) == 5'd0)
                             || (t.h == 3'd0) || (t.v == 3'd0);
        flags_next.diag_zero  = (t.d == 3'd0) || (t.a == 3'd0);
        flags_next.diag_low   = (t.d < DIAG_LOW) && (t.a < DIAG_LOW);
        flags_next.same       = (t == tf);
        flags_next.rougher    = (t.h < tf.h) || (t.v < tf.v) || (t.d < tf.d) || (t.a < tf.a);
        flags_next.conn_change = (clusters(cnt_p.col0) != clusters(cnt_f.col0))
                              || (clusters(cnt_p.col1) != clusters(cnt_f.col1));
    end

    always_comb
    begin
        logic [3:0] plus;
        logic [3:0] minus;
        plus  = SCORE_BASE;
        minus = 4'd0;
        if (flags_reg.diag_zero)
        begin
            minus = minus + 4'd2;
        end
        else if (flags_reg.diag_low)
        begin
            minus = minus + 4'd1;
        end
        if (flags_reg.same)
        begin
            plus = plus + 4'd2;
        end
        else if (flags_reg.rougher)
        begin
            minus = minus + 4'd1;
        end
        if (flags_reg.conn_change)
        begin
            minus = minus + 4'd1;
        end
        // The penalties never exceed the base, so the difference stays in 0..6.
        score_next = flags_reg.zero_score ? 3'd0 : 3'(plus - minus);
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        score_reg <= score_next;
    end

    assign score = score_reg;

endmodule
